// ----- rtl/tfb_pkg.sv -----
// Shared types and constants for the touch footer button decoder.
// Used by tfb_zone and touch_footer_button_decoder; no dependencies.
`timescale 1ns / 1ps

package tfb_pkg;

	// default panel geometry
	localparam int SCREEN_WIDTH_DEF  = 960;
	localparam int SCREEN_HEIGHT_DEF = 540;

	// relaxed footer zone: bottom band, dead band around the center column
	localparam int RELAXED_TOP = 430;
	localparam int DEAD_HALF   = 48;

	// field widths
	localparam int RAW_W   = 16;
	localparam int TIME_W  = 32;
	localparam int POS_W   = 10;
	localparam int DEB_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	// transformed coordinates go negative when mirrored; panel size < 2^16
	localparam int COORD_W = RAW_W + 2;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_PREV = 2'd1,
		ACT_NEXT = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOUCH_ENABLED = 3'd0,
		CFG_FOOTER_TOP    = 3'd1,
		CFG_FOOTER_BOTTOM = 3'd2,
		CFG_PREV_X_MIN    = 3'd3,
		CFG_PREV_X_MAX    = 3'd4,
		CFG_NEXT_X_MIN    = 3'd5,
		CFG_NEXT_X_MAX    = 3'd6,
		CFG_DEBOUNCE_MS   = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic             touch_enabled;
		logic [POS_W-1:0] footer_top;
		logic [POS_W-1:0] footer_bottom;
		logic [POS_W-1:0] prev_x_min;
		logic [POS_W-1:0] prev_x_max;
		logic [POS_W-1:0] next_x_min;
		logic [POS_W-1:0] next_x_max;
		logic [DEB_W-1:0] debounce_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		touch_enabled: 1'b0,
		footer_top:    10'd460,
		footer_bottom: 10'd539,
		prev_x_min:    10'd0,
		prev_x_max:    10'd300,
		next_x_min:    10'd660,
		next_x_max:    10'd959,
		debounce_ms:   16'd250
	};

endpackage

// ----- rtl/tfb_zone.sv -----
// Footer zone classifier for one oriented touch point: strict test, then relaxed.
// Depends on tfb_pkg.
`timescale 1ns / 1ps

module tfb_zone #(
	parameter int SCREEN_WIDTH  = tfb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tfb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic signed [tfb_pkg::COORD_W-1:0] x,
	input  logic signed [tfb_pkg::COORD_W-1:0] y,
	input  tfb_pkg::cfg_t                      cfg,
	output tfb_pkg::action_t                   action
);

	localparam int CW  = tfb_pkg::COORD_W;
	localparam int PAD = tfb_pkg::COORD_W - tfb_pkg::POS_W;

	localparam logic signed [CW-1:0] W_S      = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] H_S      = CW'(SCREEN_HEIGHT);
	localparam logic signed [CW-1:0] REL_TOP  = CW'(tfb_pkg::RELAXED_TOP);
	localparam logic signed [CW-1:0] PREV_LIM = CW'(SCREEN_WIDTH / 2 - tfb_pkg::DEAD_HALF);
	localparam logic signed [CW-1:0] NEXT_LIM = CW'(SCREEN_WIDTH / 2 + tfb_pkg::DEAD_HALF);

	logic signed [CW-1:0] ftop, fbot, pmin, pmax, nmin, nmax;
	logic on_screen, in_band, in_prev, in_next, rel_band;

	assign ftop = signed'({{PAD{1'b0}}, cfg.footer_top});
	assign fbot = signed'({{PAD{1'b0}}, cfg.footer_bottom});
	assign pmin = signed'({{PAD{1'b0}}, cfg.prev_x_min});
	assign pmax = signed'({{PAD{1'b0}}, cfg.prev_x_max});
	assign nmin = signed'({{PAD{1'b0}}, cfg.next_x_min});
	assign nmax = signed'({{PAD{1'b0}}, cfg.next_x_max});

	assign on_screen = (x >= 0) && (y >= 0) && (x < W_S) && (y < H_S);
	assign in_band   = (y >= ftop) && (y <= fbot);
	assign in_prev   = (x >= pmin) && (x <= pmax);
	assign in_next   = (x >= nmin) && (x <= nmax);
	assign rel_band  = (y >= REL_TOP);

	always_comb begin
		priority if (!on_screen) begin
			action = tfb_pkg::ACT_NONE;
		end else if (in_band && in_prev) begin
			action = tfb_pkg::ACT_PREV;
		end else if (in_band && in_next) begin
			action = tfb_pkg::ACT_NEXT;
		end else if (rel_band && (x <= PREV_LIM)) begin
			action = tfb_pkg::ACT_PREV;
		end else if (rel_band && (x >= NEXT_LIM)) begin
			action = tfb_pkg::ACT_NEXT;
		end else begin
			action = tfb_pkg::ACT_NONE;
		end
	end

endmodule

// ----- rtl/touch_footer_button_decoder.sv -----
// Top level: poll input register, debounce and press tracking, eight orientations.
// Depends on tfb_pkg and tfb_zone.
//
//   channel  direction  handshake             payload
//   poll     in         poll_valid/poll_stall touch_present, raw_x, raw_y, now_ms
//   res      out        res_valid/res_stall   action
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// One result per poll beat; one beat per cycle sustained while res_stall is low.
// A poll passes the poll register, then the result register; the zone
// compares and the 32-bit elapsed-time check sit between them.
// Reset loads the register defaults and clears the press and time state.
// A stalled result holds the poll register; poll_stall rises only then.
`timescale 1ns / 1ps

module touch_footer_button_decoder #(
	parameter int SCREEN_WIDTH  = tfb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tfb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tfb_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            poll_valid,
	output logic                            poll_stall,
	input  logic                            touch_present,
	input  logic [tfb_pkg::RAW_W-1:0]       raw_x,
	input  logic [tfb_pkg::RAW_W-1:0]       raw_y,
	input  logic [tfb_pkg::TIME_W-1:0]      now_ms,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [1:0]                      action
);

	localparam int CW  = tfb_pkg::COORD_W;
	localparam int RW  = tfb_pkg::RAW_W;
	localparam int TW  = tfb_pkg::TIME_W;
	localparam logic signed [CW-1:0] WM = CW'(SCREEN_WIDTH - 1);
	localparam logic signed [CW-1:0] HM = CW'(SCREEN_HEIGHT - 1);

	tfb_pkg::cfg_t    cfg_q;
	logic             valid_s1;
	logic             touch_present_s1;
	logic [RW-1:0]    raw_x_s1, raw_y_s1;
	logic [TW-1:0]    now_s1;
	logic             press_held_q;
	logic [TW-1:0]    last_time_q;
	logic             res_valid_q;
	tfb_pkg::action_t action_q;

	logic             advance;
	logic             accept;
	logic             deb_ok;
	logic             fire;
	tfb_pkg::action_t hit_act;
	tfb_pkg::action_t act_c;
	logic [TW-1:0]    elapsed;

	logic signed [CW-1:0] rx, ry;
	logic signed [CW-1:0] xs [8];
	logic signed [CW-1:0] ys [8];
	tfb_pkg::action_t     zone_act [8];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tfb_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (tfb_pkg::cfg_index_t'(cfg_index))
				tfb_pkg::CFG_TOUCH_ENABLED: cfg_q.touch_enabled <= cfg_data[0];
				tfb_pkg::CFG_FOOTER_TOP:    cfg_q.footer_top    <= cfg_data[tfb_pkg::POS_W-1:0];
				tfb_pkg::CFG_FOOTER_BOTTOM: cfg_q.footer_bottom <= cfg_data[tfb_pkg::POS_W-1:0];
				tfb_pkg::CFG_PREV_X_MIN:    cfg_q.prev_x_min    <= cfg_data[tfb_pkg::POS_W-1:0];
				tfb_pkg::CFG_PREV_X_MAX:    cfg_q.prev_x_max    <= cfg_data[tfb_pkg::POS_W-1:0];
				tfb_pkg::CFG_NEXT_X_MIN:    cfg_q.next_x_min    <= cfg_data[tfb_pkg::POS_W-1:0];
				tfb_pkg::CFG_NEXT_X_MAX:    cfg_q.next_x_max    <= cfg_data[tfb_pkg::POS_W-1:0];
				tfb_pkg::CFG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data[tfb_pkg::DEB_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves into the result register unless a result is stuck
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign poll_stall = valid_s1 && !advance;
	assign accept     = poll_valid && !poll_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			touch_present_s1 <= touch_present;
			raw_x_s1         <= raw_x;
			raw_y_s1         <= raw_y;
			now_s1           <= now_ms;
		end
	end

	// orientations, in priority order
	assign rx = signed'({{(CW-RW){1'b0}}, raw_x_s1});
	assign ry = signed'({{(CW-RW){1'b0}}, raw_y_s1});

	assign xs[0] = rx;      assign ys[0] = ry;
	assign xs[1] = rx;      assign ys[1] = HM - ry;
	assign xs[2] = WM - rx; assign ys[2] = ry;
	assign xs[3] = WM - rx; assign ys[3] = HM - ry;
	assign xs[4] = ry;      assign ys[4] = rx;
	assign xs[5] = ry;      assign ys[5] = HM - rx;
	assign xs[6] = WM - ry; assign ys[6] = rx;
	assign xs[7] = WM - ry; assign ys[7] = HM - rx;

	for (genvar g = 0; g < 8; g++) begin : g_orient
		tfb_zone #(
			.SCREEN_WIDTH  (SCREEN_WIDTH),
			.SCREEN_HEIGHT (SCREEN_HEIGHT)
		) u_zone (
			.x      (xs[g]),
			.y      (ys[g]),
			.cfg    (cfg_q),
			.action (zone_act[g])
		);
	end

	always_comb begin
		hit_act = tfb_pkg::ACT_NONE;
		for (int i = 7; i >= 0; i--) begin
			if (zone_act[i] != tfb_pkg::ACT_NONE) begin
				hit_act = zone_act[i];
			end
		end
	end

	// wrapping elapsed time
	assign elapsed = now_s1 - last_time_q;
	assign deb_ok  = (elapsed >= {{(TW-tfb_pkg::DEB_W){1'b0}}, cfg_q.debounce_ms});
	assign fire    = cfg_q.touch_enabled && touch_present_s1 && !press_held_q && deb_ok;
	assign act_c   = fire ? hit_act : tfb_pkg::ACT_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_held_q <= 1'b0;
			last_time_q  <= '0;
		end else if (advance && cfg_q.touch_enabled) begin
			press_held_q <= touch_present_s1;
			if (act_c != tfb_pkg::ACT_NONE) begin
				last_time_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= act_c;
		end
	end

	assign res_valid = res_valid_q;
	assign action    = action_q;

	// an action is only ever issued on a held press
	a_act_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (action_q != tfb_pkg::ACT_NONE) |-> press_held_q)
		else $error("action issued without a held press");

	a_time_rec: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (act_c != tfb_pkg::ACT_NONE) |=> last_time_q == $past(now_s1))
		else $error("action time not recorded");

	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg_q.touch_enabled |=> action_q == tfb_pkg::ACT_NONE)
		else $error("action while touch disabled");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cfg_q.touch_enabled && !touch_present_s1 |=> !press_held_q)
		else $error("press not released on empty poll");

endmodule
